/* src/asd_pkg.sv */
// Shared types, constants and helper functions of the accelerometer step detector.
package asd_pkg;

	localparam int AXIS_W = 14;
	localparam int MAG_W = 15;
	localparam int SENS_W = 15;
	localparam int CNT_W = 8;
	localparam int STEP_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;

	localparam int DEF_SMOOTH_DEPTH = 4;
	localparam int DEF_WINDOW_DEPTH = 15;
	localparam int DEF_LEVEL_DEPTH = 4;

	localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(500);
	localparam logic [CNT_W-1:0] TIMEOUT_RESET = CNT_W'(50);
	localparam logic [CNT_W-1:0] START_RESET = CNT_W'(8);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SENSITIVITY = 2'd0,
		CFG_TIMEOUT = 2'd1,
		CFG_STEPS_TO_START = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SMOOTH,
		ST_DIV,
		ST_WRITE,
		ST_SCAN,
		ST_DECIDE,
		ST_JUDGE,
		ST_DONE
	} state_t;

	function automatic logic [MAG_W-1:0] axis_abs(input logic [AXIS_W-1:0] v);
		logic [MAG_W-1:0] ext;
		ext = {v[AXIS_W-1], v};
		return v[AXIS_W-1] ? MAG_W'(~ext + MAG_W'(1)) : ext;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

/* src/accel_step_detector.sv */
// Top level of the accelerometer step detector: filter, peak search and step counting.
//
// Input beats carry an action bit and three signed 14-bit axis samples on a valid/ready
// channel; every input beat yields exactly one output beat with the step total, the
// walking flag and the number of held steps. Configuration registers are written through
// cfg_write, cfg_index and cfg_data; the user writes them only while the block is idle,
// which the block does not enforce itself. Unknown indexes are ignored. One item is worked
// on at a time. A clear action goes from acceptance straight to the done state; a
// sample before the window fills passes the smooth, divide, write, decide and done states.
// Once the window is full a sample also scans the window; a judged maximum and minimum pair
// adds a judge step, and one that updates the threshold average a divide step before it.
// The window pass reads one entry of the window memory per cycle; both averages come from
// a shared reciprocal multiplication. The next input beat can be taken in the same cycle
// as the output beat is raised, even while a finished result still waits in the output
// register; a stalled receiver only holds the block once the following result is ready.
// Reset clears the filter, window, threshold and counts and loads the register defaults;
// the window memory needs no clearing because it is read only after it has been filled.
module accel_step_detector #(
	parameter int SMOOTH_DEPTH = asd_pkg::DEF_SMOOTH_DEPTH,
	parameter int WINDOW_DEPTH = asd_pkg::DEF_WINDOW_DEPTH,
	parameter int LEVEL_DEPTH = asd_pkg::DEF_LEVEL_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [asd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [asd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic signed [asd_pkg::AXIS_W-1:0]   accel_x,
	input  logic signed [asd_pkg::AXIS_W-1:0]   accel_y,
	input  logic signed [asd_pkg::AXIS_W-1:0]   accel_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [asd_pkg::STEP_W-1:0]          step_total,
	output logic                                walking,
	output logic [asd_pkg::CNT_W-1:0]           held_steps
);
	import asd_pkg::*;

	localparam int SMOOTH_AW = $clog2(SMOOTH_DEPTH);
	localparam int LEVEL_AW = $clog2(LEVEL_DEPTH);
	localparam int WIN_AW = $clog2(WINDOW_DEPTH);
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SCAN_W = $clog2(WINDOW_DEPTH + 2);
	localparam int HALF_WIN = WINDOW_DEPTH / 2;
	localparam int SMOOTH_W = MAG_W + SMOOTH_AW;
	localparam int LEVEL_W = MAG_W + LEVEL_AW;
	localparam int DIV_W = (SMOOTH_W > LEVEL_W) ? SMOOTH_W : LEVEL_W;
	localparam int RECIP_W = DIV_W + 2;
	localparam int PROD_W = DIV_W + RECIP_W;
	localparam int SM_SHIFT = DIV_W + $clog2(SMOOTH_DEPTH);
	localparam int LV_SHIFT = DIV_W + $clog2(LEVEL_DEPTH);
	localparam logic [RECIP_W-1:0] SM_RECIP = RECIP_W'(((longint'(1) << SM_SHIFT)
		+ longint'(SMOOTH_DEPTH - 1)) / longint'(SMOOTH_DEPTH));
	localparam logic [RECIP_W-1:0] LV_RECIP = RECIP_W'(((longint'(1) << LV_SHIFT)
		+ longint'(LEVEL_DEPTH - 1)) / longint'(LEVEL_DEPTH));

	state_t state_q, state_next;

	logic [SENS_W-1:0] sens_q;
	logic [CNT_W-1:0] timeout_q;
	logic [CNT_W-1:0] start_q;

	logic [MAG_W-1:0] mag_q;
	logic [MAG_W-1:0] smooth_taps_q [SMOOTH_DEPTH];
	logic [SMOOTH_W-1:0] smooth_sum_q;
	logic [SMOOTH_AW-1:0] smooth_slot_q;
	logic [MAG_W-1:0] avg_q;

	logic [WIN_AW-1:0] window_slot_q;
	logic [FILL_W-1:0] window_fill_q;
	logic [WIN_AW-1:0] centre_q;
	logic [WIN_AW-1:0] walk_q;
	logic [SCAN_W-1:0] scan_cnt_q;
	logic [MAG_W-1:0] centre_val_q;
	logic hit_q;

	logic [MAG_W-1:0] held_max_q;
	logic [MAG_W-1:0] pair_hi_q;
	logic seeking_q;
	logic [CNT_W-1:0] since_q;

	logic [MAG_W-1:0] level_hist_q [LEVEL_DEPTH];
	logic [LEVEL_W-1:0] level_sum_q;
	logic [LEVEL_AW-1:0] level_slot_q;
	logic [MAG_W-1:0] level_thr_q;

	logic [CNT_W-1:0] run_q;
	logic [CNT_W-1:0] pending_q;
	logic walking_mode_q;
	logic [STEP_W-1:0] confirmed_q;

	logic div_sel_level_q;

	logic out_valid_q;
	logic [STEP_W-1:0] step_total_q;
	logic walking_q;
	logic [CNT_W-1:0] held_steps_q;

	logic [MAG_W-1:0] win_mem [WINDOW_DEPTH];
	logic [MAG_W-1:0] win_rdata_q;

	logic accept;
	logic win_we;
	logic win_re;
	logic out_load;
	logic [WIN_AW-1:0] win_raddr;
	logic [SMOOTH_W-1:0] smooth_sum_next;
	logic [WIN_AW-1:0] slot_next;
	logic [FILL_W-1:0] fill_next;
	logic [WIN_AW:0] centre_raw;
	logic [WIN_AW-1:0] centre_next;
	logic [DIV_W-1:0] div_num;
	logic [RECIP_W-1:0] div_recip;
	logic [PROD_W-1:0] div_prod;
	logic [MAG_W-1:0] div_quot;
	logic found;
	logic judge_go;
	logic timeout_hit;
	logic swing_ok;
	logic [MAG_W:0] pair_sum;
	logic [MAG_W-1:0] midpoint;
	logic [LEVEL_W-1:0] level_sum_next;
	logic [SENS_W-2:0] half_sens;
	logic step_ok;
	logic [CNT_W-1:0] run_inc;
	logic [CNT_W-1:0] pend_inc;
	logic [CNT_W-1:0] since_inc;

	always_comb begin
		smooth_sum_next = smooth_sum_q - SMOOTH_W'(smooth_taps_q[smooth_slot_q])
			+ SMOOTH_W'(mag_q);
		slot_next = (window_slot_q == WIN_AW'(WINDOW_DEPTH - 1)) ? '0
			: window_slot_q + WIN_AW'(1);
		fill_next = (window_fill_q == FILL_W'(WINDOW_DEPTH)) ? window_fill_q
			: window_fill_q + FILL_W'(1);
		centre_raw = {1'b0, slot_next} + (WIN_AW + 1)'(HALF_WIN);
		centre_next = (centre_raw >= (WIN_AW + 1)'(WINDOW_DEPTH))
			? WIN_AW'(centre_raw - (WIN_AW + 1)'(WINDOW_DEPTH)) : WIN_AW'(centre_raw);
		win_raddr = (scan_cnt_q == '0) ? centre_q : walk_q;

		div_num = div_sel_level_q ? DIV_W'(level_sum_q) : DIV_W'(smooth_sum_q);
		div_recip = div_sel_level_q ? LV_RECIP : SM_RECIP;
		div_prod = PROD_W'(div_num) * PROD_W'(div_recip);
		div_quot = div_sel_level_q ? MAG_W'(div_prod >> LV_SHIFT)
			: MAG_W'(div_prod >> SM_SHIFT);

		found = (window_fill_q == FILL_W'(WINDOW_DEPTH)) && !hit_q;
		since_inc = sat_inc(since_q);
		judge_go = seeking_q && found;
		timeout_hit = seeking_q && !found && (since_inc >= timeout_q);
		swing_ok = {1'b0, held_max_q} > ({1'b0, centre_val_q} + {1'b0, sens_q});
		pair_sum = {1'b0, held_max_q} + {1'b0, centre_val_q};
		midpoint = pair_sum[MAG_W:1];
		level_sum_next = level_sum_q - LEVEL_W'(level_hist_q[level_slot_q])
			+ LEVEL_W'(midpoint);

		half_sens = sens_q[SENS_W-1:1];
		step_ok = ({1'b0, pair_hi_q} > ({1'b0, level_thr_q} + (MAG_W + 1)'(half_sens)))
			&& (({1'b0, centre_val_q} + (MAG_W + 1)'(half_sens)) < {1'b0, level_thr_q});
		run_inc = sat_inc(run_q);
		pend_inc = sat_inc(pending_q);
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = action ? ST_DONE : ST_SMOOTH;
				end
			end
			ST_SMOOTH: state_next = ST_DIV;
			ST_DIV: state_next = div_sel_level_q ? ST_JUDGE : ST_WRITE;
			ST_WRITE: begin
				state_next = (fill_next == FILL_W'(WINDOW_DEPTH)) ? ST_SCAN : ST_DECIDE;
			end
			ST_SCAN: begin
				if (scan_cnt_q == SCAN_W'(WINDOW_DEPTH + 1)) begin
					state_next = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (judge_go) begin
					state_next = swing_ok ? ST_DIV : ST_JUDGE;
				end else begin
					state_next = ST_DONE;
				end
			end
			ST_JUDGE: state_next = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		win_we = (state_q == ST_WRITE);
		win_re = (state_q == ST_SCAN) && (scan_cnt_q <= SCAN_W'(WINDOW_DEPTH));
		out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
		accept = in_valid && in_ready;
	end

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[window_slot_q] <= avg_q;
		end
		if (win_re) begin
			win_rdata_q <= win_mem[win_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q <= SENS_RESET;
			timeout_q <= TIMEOUT_RESET;
			start_q <= START_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SENSITIVITY: sens_q <= cfg_data[SENS_W-1:0];
				CFG_TIMEOUT: timeout_q <= cfg_data[CNT_W-1:0];
				CFG_STEPS_TO_START: start_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= axis_abs(accel_x) + axis_abs(accel_y) + axis_abs(accel_z);
		end
		if (state_q == ST_SCAN) begin
			if (scan_cnt_q == SCAN_W'(1)) begin
				centre_val_q <= win_rdata_q;
			end
		end
		if (state_q == ST_DECIDE) begin
			pair_hi_q <= held_max_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SMOOTH_DEPTH; i++) begin
				smooth_taps_q[i] <= '0;
			end
			smooth_sum_q <= '0;
			smooth_slot_q <= '0;
			avg_q <= '0;
			div_sel_level_q <= 1'b0;
		end else begin
			if (state_q == ST_SMOOTH) begin
				smooth_taps_q[smooth_slot_q] <= mag_q;
				smooth_sum_q <= smooth_sum_next;
				smooth_slot_q <= (smooth_slot_q == SMOOTH_AW'(SMOOTH_DEPTH - 1)) ? '0
					: smooth_slot_q + SMOOTH_AW'(1);
				div_sel_level_q <= 1'b0;
			end else if (state_q == ST_DECIDE && judge_go && swing_ok) begin
				div_sel_level_q <= 1'b1;
			end else if (state_q == ST_DIV && !div_sel_level_q) begin
				avg_q <= div_quot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_slot_q <= '0;
			window_fill_q <= '0;
			centre_q <= '0;
			walk_q <= '0;
			scan_cnt_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (state_q == ST_WRITE) begin
				window_slot_q <= slot_next;
				window_fill_q <= fill_next;
				centre_q <= centre_next;
				walk_q <= slot_next;
				scan_cnt_q <= '0;
				hit_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + SCAN_W'(1);
				if (win_re && scan_cnt_q != '0) begin
					walk_q <= (walk_q == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : walk_q + WIN_AW'(1);
				end
				if (scan_cnt_q > SCAN_W'(1)) begin
					if (seeking_q ? (win_rdata_q < centre_val_q) : (win_rdata_q > centre_val_q))
						begin
						hit_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_max_q <= '0;
			seeking_q <= 1'b0;
			since_q <= '0;
			for (int i = 0; i < LEVEL_DEPTH; i++) begin
				level_hist_q[i] <= '0;
			end
			level_sum_q <= '0;
			level_slot_q <= '0;
			level_thr_q <= '0;
			run_q <= '0;
			pending_q <= '0;
			walking_mode_q <= 1'b0;
			confirmed_q <= '0;
		end else begin
			if (accept && action) begin
				confirmed_q <= '0;
				pending_q <= '0;
				run_q <= '0;
				walking_mode_q <= 1'b0;
			end
			if (state_q == ST_DECIDE) begin
				if (!seeking_q) begin
					if (found) begin
						held_max_q <= centre_val_q;
						seeking_q <= 1'b1;
						since_q <= '0;
					end
				end else begin
					since_q <= since_inc;
					if (found || timeout_hit) begin
						seeking_q <= 1'b0;
						held_max_q <= '0;
					end
					if (timeout_hit && !walking_mode_q) begin
						run_q <= '0;
						pending_q <= '0;
					end
					if (judge_go && swing_ok) begin
						level_hist_q[level_slot_q] <= midpoint;
						level_sum_q <= level_sum_next;
						level_slot_q <= (level_slot_q == LEVEL_AW'(LEVEL_DEPTH - 1)) ? '0
							: level_slot_q + LEVEL_AW'(1);
					end
				end
			end
			if (state_q == ST_DIV && div_sel_level_q) begin
				level_thr_q <= div_quot;
			end
			if (state_q == ST_JUDGE) begin
				if (step_ok) begin
					if (walking_mode_q) begin
						confirmed_q <= confirmed_q + STEP_W'(1);
					end else begin
						run_q <= run_inc;
						if (run_inc >= start_q) begin
							walking_mode_q <= 1'b1;
							confirmed_q <= confirmed_q + STEP_W'(pend_inc);
							pending_q <= '0;
						end else begin
							pending_q <= pend_inc;
						end
					end
				end else if (!walking_mode_q) begin
					run_q <= '0;
					pending_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			step_total_q <= confirmed_q;
			walking_q <= walking_mode_q;
			held_steps_q <= pending_q;
		end
	end

	assign out_valid = out_valid_q;
	assign step_total = step_total_q;
	assign walking = walking_q;
	assign held_steps = held_steps_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("Block stayed idle after taking an input beat.");

	a_no_pending_when_walking: assert property (@(posedge clk) disable iff (!arst_n)
		walking_mode_q |-> pending_q == '0)
		else $error("Held steps remain while in walking mode.");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		window_fill_q <= FILL_W'(WINDOW_DEPTH))
		else $error("Window fill count exceeds the window depth.");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("Output beat raised outside the completion state.");

	a_scan_reads_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		win_we |-> !win_re && state_q == ST_WRITE)
		else $error("Window memory written during the window pass.");

endmodule
